### rtl/jkde_pkg.sv
package jkde_pkg;

  localparam logic [3:0] KEY_LEN = 4'd11;

  localparam logic [1:0] PHASE_SPACE  = 2'd0;
  localparam logic [1:0] PHASE_SIGN   = 2'd1;
  localparam logic [1:0] PHASE_DIGITS = 2'd2;
  localparam logic [1:0] PHASE_BAD    = 2'd3;

  localparam logic [1:0] STATUS_SUCCESS = 2'd0;
  localparam logic [1:0] STATUS_FAIL    = 2'd1;
  localparam logic [1:0] STATUS_WAITING = 2'd2;

  // 2^64 = QUOT_2P64 * 1000 + REM_2P64; (2^64 - 1) / 1000 has the same quotient
  localparam logic [63:0] QUOT_2P64 = 64'd18446744073709551;
  localparam logic [9:0]  REM_2P64  = 10'd616;

  // value_quot/value_rem track value_accumulator as quot * 1000 + rem (quot mod 2^32)
  typedef struct packed {
    logic        text_ended;
    logic        in_token;
    logic [3:0]  key_position;
    logic        key_mismatch;
    logic        expect_value;
    logic [1:0]  value_phase;
    logic        value_negative;
    logic        value_saturated;
    logic [63:0] value_accumulator;
    logic [31:0] value_quot;
    logic [9:0]  value_rem;
    logic        number_found;
    logic [31:0] found_seconds;
    logic [2:0]  invalid_match_pos;
    logic [2:0]  fail_match_pos;
    logic        error_word_seen;
  } jkde_state_t;

  localparam jkde_state_t STATE_RESET = '0;

  function automatic logic [7:0] key_char(input logic [3:0] pos);
    case (pos)
      4'd0:    key_char = "s";
      4'd1:    key_char = "e";
      4'd2:    key_char = "r";
      4'd3:    key_char = "v";
      4'd4:    key_char = "e";
      4'd5:    key_char = "r";
      4'd6:    key_char = "_";
      4'd7:    key_char = "t";
      4'd8:    key_char = "i";
      4'd9:    key_char = "m";
      4'd10:   key_char = "e";
      default: key_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] invalid_char(input logic [2:0] pos);
    case (pos)
      3'd0:    invalid_char = "i";
      3'd1:    invalid_char = "n";
      3'd2:    invalid_char = "v";
      3'd3:    invalid_char = "a";
      3'd4:    invalid_char = "l";
      3'd5:    invalid_char = "i";
      3'd6:    invalid_char = "d";
      default: invalid_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] fail_char(input logic [2:0] pos);
    case (pos)
      3'd0:    fail_char = "f";
      3'd1:    fail_char = "a";
      3'd2:    fail_char = "i";
      3'd3:    fail_char = "l";
      default: fail_char = 8'h00;
    endcase
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    is_delim = (c == "{") || (c == "}") || (c == ",") || (c == "[") || (c == "]") ||
               (c == "/") || (c == " ") || (c == "+") || (c == 8'h22) || (c == ":");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'h09) || (c == 8'h0a) || (c == 8'h0b) || (c == 8'h0c) ||
               (c == 8'h0d) || (c == 8'h20);
  endfunction

  function automatic logic [3:0] div1000(input logic [13:0] t);
    if (t >= 14'd9000)      div1000 = 4'd9;
    else if (t >= 14'd8000) div1000 = 4'd8;
    else if (t >= 14'd7000) div1000 = 4'd7;
    else if (t >= 14'd6000) div1000 = 4'd6;
    else if (t >= 14'd5000) div1000 = 4'd5;
    else if (t >= 14'd4000) div1000 = 4'd4;
    else if (t >= 14'd3000) div1000 = 4'd3;
    else if (t >= 14'd2000) div1000 = 4'd2;
    else if (t >= 14'd1000) div1000 = 4'd1;
    else                    div1000 = 4'd0;
  endfunction

  function automatic logic [13:0] mul1000(input logic [3:0] q);
    case (q)
      4'd1:    mul1000 = 14'd1000;
      4'd2:    mul1000 = 14'd2000;
      4'd3:    mul1000 = 14'd3000;
      4'd4:    mul1000 = 14'd4000;
      4'd5:    mul1000 = 14'd5000;
      4'd6:    mul1000 = 14'd6000;
      4'd7:    mul1000 = 14'd7000;
      4'd8:    mul1000 = 14'd8000;
      4'd9:    mul1000 = 14'd9000;
      default: mul1000 = 14'd0;
    endcase
  endfunction

  // quotient of the signed/saturated value by 1000, low 32 bits
  function automatic logic [31:0] value_seconds(input jkde_state_t s);
    logic [31:0] borrow;
    borrow = {31'd0, (s.value_rem > REM_2P64)};
    if (s.value_saturated)
      value_seconds = QUOT_2P64[31:0];
    else if (s.value_negative) begin
      if (s.value_accumulator == 64'd0)
        value_seconds = 32'd0;
      else
        value_seconds = QUOT_2P64[31:0] - s.value_quot - borrow;
    end else
      value_seconds = s.value_quot;
  endfunction

  function automatic jkde_state_t end_token(input jkde_state_t s);
    jkde_state_t r;
    r = s;
    if (s.in_token) begin
      r.in_token = 1'b0;
      if (!s.number_found) begin
        if (s.expect_value) begin
          r.expect_value = 1'b0;
          if (s.value_phase == PHASE_DIGITS) begin
            r.found_seconds = value_seconds(s);
            r.number_found  = 1'b1;
          end
        end else if (!s.key_mismatch && s.key_position == KEY_LEN) begin
          r.expect_value = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic jkde_state_t token_byte(input jkde_state_t s, input logic [7:0] c);
    jkde_state_t r;
    logic [3:0]  d;
    logic [67:0] wide;
    logic [13:0] t;
    logic [3:0]  qd;
    logic [13:0] rem_wide;
    r = s;
    d = c[3:0];
    if (!r.in_token) begin
      r.in_token          = 1'b1;
      r.key_position      = 4'd0;
      r.key_mismatch      = 1'b0;
      r.value_phase       = PHASE_SPACE;
      r.value_negative    = 1'b0;
      r.value_saturated   = 1'b0;
      r.value_accumulator = 64'd0;
      r.value_quot        = 32'd0;
      r.value_rem         = 10'd0;
    end
    wide = {1'b0, r.value_accumulator, 3'b000} + {3'b000, r.value_accumulator, 1'b0} +
           {64'd0, d};
    t = {1'b0, r.value_rem, 3'b000} + {3'b000, r.value_rem, 1'b0} + {10'd0, d};
    qd = div1000(t);
    rem_wide = t - mul1000(qd);
    if (!r.number_found) begin
      if (r.expect_value) begin
        if (c >= "0" && c <= "9") begin
          if (r.value_phase != PHASE_BAD) begin
            r.value_phase = PHASE_DIGITS;
            if (!r.value_saturated) begin
              if (wide[67:64] != 4'd0)
                r.value_saturated = 1'b1;
              else begin
                r.value_accumulator = wide[63:0];
                r.value_quot = {r.value_quot[28:0], 3'b000} + {r.value_quot[30:0], 1'b0} +
                               {28'd0, qd};
                r.value_rem  = rem_wide[9:0];
              end
            end
          end
        end else if (r.value_phase == PHASE_SPACE && is_space(c)) begin
          r.value_phase = PHASE_SPACE;
        end else if (r.value_phase == PHASE_SPACE && c == "-") begin
          r.value_negative = 1'b1;
          r.value_phase    = PHASE_SIGN;
        end else begin
          r.value_phase = PHASE_BAD;
        end
      end else begin
        if (r.key_position < KEY_LEN && key_char(r.key_position) == c)
          r.key_position = r.key_position + 4'd1;
        else
          r.key_mismatch = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic jkde_state_t text_byte(input jkde_state_t s, input logic [7:0] c);
    jkde_state_t r;
    logic [2:0]  p;
    r = s;
    // substring matchers; "invalid" can restart on "i" or on "in" after "invali"
    if (invalid_char(s.invalid_match_pos) == c)
      p = s.invalid_match_pos + 3'd1;
    else if (s.invalid_match_pos == 3'd6 && c == "n")
      p = 3'd2;
    else if (c == "i")
      p = 3'd1;
    else
      p = 3'd0;
    if (p == 3'd7) begin
      r.error_word_seen = 1'b1;
      p = 3'd0;
    end
    r.invalid_match_pos = p;
    if (fail_char(s.fail_match_pos) == c)
      p = s.fail_match_pos + 3'd1;
    else if (c == "f")
      p = 3'd1;
    else
      p = 3'd0;
    if (p == 3'd4) begin
      r.error_word_seen = 1'b1;
      p = 3'd0;
    end
    r.fail_match_pos = p;
    if (is_delim(c))
      r = end_token(r);
    else
      r = token_byte(r, c);
    return r;
  endfunction

endpackage

### rtl/jkde_in_if.sv
interface jkde_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/jkde_out_if.sv
interface jkde_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] seconds;

  modport source (output valid, output status, output seconds, input ready);
  modport sink (input valid, input status, input seconds, output ready);
endinterface

### rtl/json_key_decimal_extractor.sv
// The result is registered: it is valid in the cycle after the final byte is accepted.
// Throughput: one byte per cycle when not stalled; every byte is parsed in the cycle it is accepted.
// While a result waits in the output register the input stalls; a result taken in the
// same cycle lets the next byte in without a gap.
// Reset (synchronous, active high) clears the parser state and the output valid flag.
// After each final byte the parser returns to its reset state for the next reply.
module json_key_decimal_extractor
  import jkde_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  jkde_in_if.sink    din,
  jkde_out_if.source dout
);

  jkde_state_t st;
  jkde_state_t st_next;
  jkde_state_t after_byte;
  jkde_state_t after_last;

  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_seconds;
  logic        accept;
  logic [1:0]  status_next;
  logic [31:0] seconds_next;

  assign din.ready = !out_valid || dout.ready;
  assign accept    = din.valid && din.ready;

  always_comb begin
    after_byte = st;
    if (!st.text_ended) begin
      if (din.data_byte == 8'h00) begin
        after_byte.text_ended = 1'b1;
        after_byte = end_token(after_byte);
      end else begin
        after_byte = text_byte(st, din.data_byte);
      end
    end
    // the final byte closes the text and any open token
    after_last = after_byte;
    if (!after_byte.text_ended) begin
      after_last.text_ended = 1'b1;
      after_last = end_token(after_last);
    end
    if (after_last.error_word_seen) begin
      status_next  = STATUS_FAIL;
      seconds_next = 32'd0;
    end else if (after_last.number_found) begin
      status_next  = STATUS_SUCCESS;
      seconds_next = after_last.found_seconds;
    end else begin
      status_next  = STATUS_WAITING;
      seconds_next = 32'd0;
    end
    if (!accept)
      st_next = st;
    else if (din.last_byte)
      st_next = STATE_RESET;
    else
      st_next = after_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (accept && din.last_byte)
        out_valid <= 1'b1;
      else if (dout.ready)
        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && din.last_byte) begin
      out_status  <= status_next;
      out_seconds <= seconds_next;
    end
  end

  assign dout.valid   = out_valid;
  assign dout.status  = out_status;
  assign dout.seconds = out_seconds;

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && din.last_byte |=> dout.valid)
    else $error("final byte did not produce a result");

  a_reply_restart: assert property (@(posedge clk) disable iff (rst)
    accept && din.last_byte |=> !st.in_token && !st.text_ended && !st.number_found &&
                               !st.error_word_seen)
    else $error("parser not back at reset after final byte");

  a_seconds_zero: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.status != STATUS_SUCCESS |-> dout.seconds == 32'd0)
    else $error("seconds nonzero on a non-success result");

  a_found_no_expect: assert property (@(posedge clk) disable iff (rst)
    st.number_found |-> !st.expect_value)
    else $error("still expecting a value after a number was latched");

endmodule
